FILE: rtl/ltrk_pkg.sv
// Shared types, widths and codes for the log garbage tracker.
`timescale 1ns / 1ps
`default_nettype none
package ltrk_pkg;

  localparam int OP_W  = 4;
  localparam int ID_W  = 24;
  localparam int GC_W  = 40;
  localparam int AMT_W = 32;
  localparam int ST_W  = 2;

  localparam logic [OP_W-1:0] OP_ADD      = 4'd0;
  localparam logic [OP_W-1:0] OP_REMOVE   = 4'd1;
  localparam logic [OP_W-1:0] OP_ADD_GC   = 4'd2;
  localparam logic [OP_W-1:0] OP_SET_CUR  = 4'd3;
  localparam logic [OP_W-1:0] OP_SET_SORT = 4'd4;
  localparam logic [OP_W-1:0] OP_MARK     = 4'd5;
  localparam logic [OP_W-1:0] OP_UNMARK   = 4'd6;
  localparam logic [OP_W-1:0] OP_QUERY    = 4'd7;
  localparam logic [OP_W-1:0] OP_PICK     = 4'd8;

  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [ST_W-1:0] ST_TBL_FULL  = 2'd2;
  localparam logic [ST_W-1:0] ST_NO_CLEAN  = 2'd3;

  localparam logic [GC_W-1:0] THRESH_RST = 40'd1048576;
  localparam logic [GC_W-1:0] GC_MAX     = {GC_W{1'b1}};

  // Summary gathered by one pass over the table.
  typedef struct packed {
    logic            found;
    logic [GC_W-1:0] found_cnt;
    logic            free_found;
    logic            old_found;
    logic            old_hot;
    logic            best_found;
    logic [ID_W-1:0] best_id;
    logic [GC_W-1:0] best_cnt;
  } scan_res_t;

endpackage
`default_nettype wire

FILE: rtl/ltrk_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module ltrk_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

FILE: rtl/ltrk_scan.sv
// Table scan unit: one entry per cycle through a shared count comparator.
`timescale 1ns / 1ps
`default_nettype none
module ltrk_scan #(
  parameter int TABLE_DEPTH = 64
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           clr,
  input  wire logic                           ent_en,
  input  wire logic [$clog2(TABLE_DEPTH)-1:0] ent_idx,
  input  wire logic                           ent_vld,
  input  wire logic                           ent_full,
  input  wire logic [ltrk_pkg::ID_W-1:0]      ent_id,
  input  wire logic [ltrk_pkg::GC_W-1:0]      ent_cnt,
  input  wire logic [ltrk_pkg::ID_W-1:0]      key_id,
  input  wire logic [ltrk_pkg::ID_W-1:0]      old_id,
  input  wire logic [ltrk_pkg::GC_W-1:0]      thresh,
  output ltrk_pkg::scan_res_t                 res,
  output logic [$clog2(TABLE_DEPTH)-1:0]      found_idx,
  output logic [$clog2(TABLE_DEPTH)-1:0]      free_idx,
  output logic [$clog2(TABLE_DEPTH)-1:0]      old_idx
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);

  ltrk_pkg::scan_res_t res_r, res_nxt;
  logic [IDX_W-1:0]    found_idx_r, found_idx_nxt;
  logic [IDX_W-1:0]    free_idx_r, free_idx_nxt;
  logic [IDX_W-1:0]    old_idx_r, old_idx_nxt;
  logic                better;

  // The shared comparator: larger count wins, lower id breaks a tie.
  assign better = !res_r.best_found || (ent_cnt > res_r.best_cnt) ||
                  ((ent_cnt == res_r.best_cnt) && (ent_id < res_r.best_id));

  always_comb begin
    res_nxt       = res_r;
    found_idx_nxt = found_idx_r;
    free_idx_nxt  = free_idx_r;
    old_idx_nxt   = old_idx_r;
    if (clr) begin
      res_nxt.found      = 1'b0;
      res_nxt.free_found = 1'b0;
      res_nxt.old_found  = 1'b0;
      res_nxt.best_found = 1'b0;
    end else if (ent_en) begin
      if (ent_vld && (ent_id == key_id) && !res_r.found) begin
        res_nxt.found     = 1'b1;
        res_nxt.found_cnt = ent_cnt;
        found_idx_nxt     = ent_idx;
      end
      if (ent_vld && (ent_id == old_id) && !res_r.old_found) begin
        res_nxt.old_found = 1'b1;
        res_nxt.old_hot   = (ent_cnt >= thresh);
        old_idx_nxt       = ent_idx;
      end
      if (!ent_vld && !res_r.free_found) begin
        res_nxt.free_found = 1'b1;
        free_idx_nxt       = ent_idx;
      end
      if (ent_vld && ent_full && better) begin
        res_nxt.best_found = 1'b1;
        res_nxt.best_id    = ent_id;
        res_nxt.best_cnt   = ent_cnt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r.found      <= 1'b0;
      res_r.free_found <= 1'b0;
      res_r.old_found  <= 1'b0;
      res_r.best_found <= 1'b0;
    end else begin
      res_r.found      <= res_nxt.found;
      res_r.free_found <= res_nxt.free_found;
      res_r.old_found  <= res_nxt.old_found;
      res_r.best_found <= res_nxt.best_found;
    end
    res_r.found_cnt <= res_nxt.found_cnt;
    res_r.old_hot   <= res_nxt.old_hot;
    res_r.best_id   <= res_nxt.best_id;
    res_r.best_cnt  <= res_nxt.best_cnt;
    found_idx_r     <= found_idx_nxt;
    free_idx_r      <= free_idx_nxt;
    old_idx_r       <= old_idx_nxt;
  end

  assign res       = res_r;
  assign found_idx = found_idx_r;
  assign free_idx  = free_idx_r;
  assign old_idx   = old_idx_r;

endmodule
`default_nettype wire

FILE: rtl/log_garbage_tracker_top.sv
// Top level of the log garbage tracker: sequencer, table state and result register.
`timescale 1ns / 1ps
`default_nettype none
//
//  Channel   Handshake            Payload
//  --------  -------------------  ------------------------------------------------
//  input     start / busy         in_operation, in_log_id, in_amount
//  result    out_valid (strobe)   out_status, out_result_log, out_garbage_count,
//                                 out_needs_clean, out_any_full
//  config    cfg_wr_en            cfg_wr_data (garbage threshold)
//
// A word is taken when start is high and busy is low. Busy then stays high while the
// sequencer steps through the table one entry at a time through the single RAM read
// port, drains the registered read and applies the operation. The result word is
// strobed for one cycle after that; the receiver cannot stall.
// Synchronous active-low reset clears the valid and full marks and both log
// registers and restores the default threshold; ids and counts need no clearing.
//
module log_garbage_tracker_top #(
  parameter int TABLE_DEPTH = 64
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [ltrk_pkg::OP_W-1:0]    in_operation,
  input  wire logic [ltrk_pkg::ID_W-1:0]    in_log_id,
  input  wire logic [ltrk_pkg::AMT_W-1:0]   in_amount,
  output logic                              out_valid,
  output logic [ltrk_pkg::ST_W-1:0]         out_status,
  output logic [ltrk_pkg::ID_W-1:0]         out_result_log,
  output logic [ltrk_pkg::GC_W-1:0]         out_garbage_count,
  output logic                              out_needs_clean,
  output logic                              out_any_full,
  input  wire logic                         cfg_wr_en,
  input  wire logic [ltrk_pkg::GC_W-1:0]    cfg_wr_data
);

  localparam int IDX_W  = $clog2(TABLE_DEPTH);
  localparam int FC_W   = $clog2(TABLE_DEPTH + 1);
  localparam int ID_W   = ltrk_pkg::ID_W;
  localparam int GC_W   = ltrk_pkg::GC_W;
  localparam int RAM_W  = ID_W + GC_W;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_EXEC  = 2'd3;

  logic [1:0]                   state_r, state_nxt;
  logic [IDX_W-1:0]             scan_idx_r;
  logic                         rd_vld_r;
  logic [IDX_W-1:0]             rd_idx_r;

  // The latched command word.
  logic [ltrk_pkg::OP_W-1:0]    op_r;
  logic [ID_W-1:0]              id_r;
  logic [ltrk_pkg::AMT_W-1:0]   amt_r;

  logic [GC_W-1:0]              thresh_r;
  logic [ID_W-1:0]              cur_r, sort_r;
  logic [TABLE_DEPTH-1:0]       valid_r, full_r;
  logic [FC_W-1:0]              full_cnt_r, full_cnt_nxt;

  logic                         ram_we;
  logic [IDX_W-1:0]             ram_waddr;
  logic [RAM_W-1:0]             ram_wdata, ram_rdata;

  ltrk_pkg::scan_res_t          scan_res;
  logic [IDX_W-1:0]             found_idx, free_idx, old_idx;
  logic [ID_W-1:0]              old_key;
  logic                         accept;

  // Table updates decided in the apply cycle.
  logic                         v_set, v_clr, f_set, f_clr;
  logic [IDX_W-1:0]             v_idx, f_idx;
  logic                         cur_we, sort_we;
  logic [ltrk_pkg::ST_W-1:0]    st_nxt;
  logic [ID_W-1:0]              rlog_nxt;
  logic [GC_W-1:0]              cnt_nxt;
  logic                         have_nxt;
  logic [GC_W:0]                sum;
  logic [GC_W-1:0]              sat_cnt;
  logic                         f_inc, f_dec;

  logic                         out_valid_r;
  logic [ltrk_pkg::ST_W-1:0]    out_status_r;
  logic [ID_W-1:0]              out_rlog_r;
  logic [GC_W-1:0]              out_cnt_r;
  logic                         out_nc_r, out_af_r;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  // The old log of whichever register the command would switch.
  assign old_key = (op_r == ltrk_pkg::OP_SET_CUR) ? cur_r : sort_r;

  ltrk_ram #(
    .WIDTH (RAM_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (scan_idx_r),
    .rd_data (ram_rdata)
  );

  ltrk_scan #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .clr       (accept),
    .ent_en    (rd_vld_r),
    .ent_idx   (rd_idx_r),
    .ent_vld   (valid_r[rd_idx_r]),
    .ent_full  (full_r[rd_idx_r]),
    .ent_id    (ram_rdata[RAM_W-1:GC_W]),
    .ent_cnt   (ram_rdata[GC_W-1:0]),
    .key_id    (id_r),
    .old_id    (old_key),
    .thresh    (thresh_r),
    .res       (scan_res),
    .found_idx (found_idx),
    .free_idx  (free_idx),
    .old_idx   (old_idx)
  );

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_idx_r == IDX_W'(TABLE_DEPTH - 1)) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Saturating garbage add for the add-garbage command.
  assign sum     = {1'b0, scan_res.found_cnt} + {{(GC_W + 1 - ltrk_pkg::AMT_W){1'b0}}, amt_r};
  assign sat_cnt = sum[GC_W] ? ltrk_pkg::GC_MAX : sum[GC_W-1:0];

  // Apply the command once the whole table has been seen.
  always_comb begin
    v_set     = 1'b0;
    v_clr     = 1'b0;
    f_set     = 1'b0;
    f_clr     = 1'b0;
    v_idx     = found_idx;
    f_idx     = found_idx;
    cur_we    = 1'b0;
    sort_we   = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = found_idx;
    ram_wdata = {id_r, {GC_W{1'b0}}};
    st_nxt    = ltrk_pkg::ST_OK;
    rlog_nxt  = id_r;
    cnt_nxt   = '0;
    have_nxt  = 1'b0;
    unique case (op_r) inside
      ltrk_pkg::OP_ADD: begin
        if (scan_res.found) begin
          ram_we   = 1'b1;
          have_nxt = 1'b1;
        end else if (scan_res.free_found) begin
          ram_we    = 1'b1;
          ram_waddr = free_idx;
          v_set     = 1'b1;
          v_idx     = free_idx;
          have_nxt  = 1'b1;
        end else begin
          st_nxt = ltrk_pkg::ST_TBL_FULL;
        end
      end
      ltrk_pkg::OP_REMOVE: begin
        if (scan_res.found) begin
          cnt_nxt  = scan_res.found_cnt;
          have_nxt = 1'b1;
          v_clr    = 1'b1;
          f_clr    = 1'b1;
        end else begin
          st_nxt = ltrk_pkg::ST_NOT_FOUND;
        end
      end
      ltrk_pkg::OP_ADD_GC: begin
        if (scan_res.found) begin
          cnt_nxt   = sat_cnt;
          have_nxt  = 1'b1;
          ram_we    = 1'b1;
          ram_wdata = {id_r, sat_cnt};
          if ((id_r != cur_r) && (id_r != sort_r) && (sat_cnt >= thresh_r)) begin
            f_set = 1'b1;
          end
        end else begin
          st_nxt = ltrk_pkg::ST_NOT_FOUND;
        end
      end
      ltrk_pkg::OP_SET_CUR, ltrk_pkg::OP_SET_SORT: begin
        cur_we  = (op_r == ltrk_pkg::OP_SET_CUR);
        sort_we = (op_r == ltrk_pkg::OP_SET_SORT);
        // The outgoing log is retired when the new id directly follows it and its count has reached the threshold.
        if ((id_r != '0) && (old_key == id_r - ID_W'(1)) &&
            scan_res.old_found && scan_res.old_hot) begin
          f_set = 1'b1;
          f_idx = old_idx;
        end
        if (scan_res.found) begin
          cnt_nxt  = scan_res.found_cnt;
          have_nxt = 1'b1;
        end
      end
      ltrk_pkg::OP_MARK, ltrk_pkg::OP_UNMARK, ltrk_pkg::OP_QUERY: begin
        if (scan_res.found) begin
          cnt_nxt  = scan_res.found_cnt;
          have_nxt = 1'b1;
          f_set    = (op_r == ltrk_pkg::OP_MARK);
          f_clr    = (op_r == ltrk_pkg::OP_UNMARK);
        end else begin
          st_nxt = ltrk_pkg::ST_NOT_FOUND;
        end
      end
      ltrk_pkg::OP_PICK: begin
        if (scan_res.best_found) begin
          rlog_nxt = scan_res.best_id;
          cnt_nxt  = scan_res.best_cnt;
          have_nxt = 1'b1;
        end else begin
          st_nxt   = ltrk_pkg::ST_NO_CLEAN;
          rlog_nxt = '0;
        end
      end
      default: begin
      end
    endcase
    if (state_r != S_EXEC) begin
      v_set   = 1'b0;
      v_clr   = 1'b0;
      f_set   = 1'b0;
      f_clr   = 1'b0;
      cur_we  = 1'b0;
      sort_we = 1'b0;
      ram_we  = 1'b0;
    end
  end

  // Running count of full entries gives the any-full flag without a wide OR.
  assign f_inc        = f_set && !full_r[f_idx];
  assign f_dec        = f_clr && full_r[f_idx];
  assign full_cnt_nxt = full_cnt_r + FC_W'(f_inc) - FC_W'(f_dec);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rd_vld_r    <= 1'b0;
      thresh_r    <= ltrk_pkg::THRESH_RST;
      cur_r       <= '0;
      sort_r      <= '0;
      valid_r     <= '0;
      full_r      <= '0;
      full_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_vld_r    <= (state_r == S_SCAN);
      out_valid_r <= (state_r == S_EXEC);
      full_cnt_r  <= full_cnt_nxt;
      if (cfg_wr_en) begin
        thresh_r <= cfg_wr_data;
      end
      if (cur_we) begin
        cur_r <= id_r;
      end
      if (sort_we) begin
        sort_r <= id_r;
      end
      if (v_set) begin
        valid_r[v_idx] <= 1'b1;
      end
      if (v_clr) begin
        valid_r[v_idx] <= 1'b0;
      end
      if (f_set) begin
        full_r[f_idx] <= 1'b1;
      end
      if (f_clr) begin
        full_r[f_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= scan_idx_r;
    if (accept) begin
      op_r       <= in_operation;
      id_r       <= in_log_id;
      amt_r      <= in_amount;
      scan_idx_r <= '0;
    end else if (state_r == S_SCAN) begin
      scan_idx_r <= scan_idx_r + IDX_W'(1);
    end
    if (state_r == S_EXEC) begin
      out_status_r <= st_nxt;
      out_rlog_r   <= rlog_nxt;
      out_cnt_r    <= cnt_nxt;
      out_nc_r     <= have_nxt && (cnt_nxt >= thresh_r);
      out_af_r     <= (full_cnt_nxt != '0);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_result_log    = out_rlog_r;
  assign out_garbage_count = out_cnt_r;
  assign out_needs_clean   = out_nc_r;
  assign out_any_full      = out_af_r;

  // A word never produces two strobes in a row.
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  // The full-entry count agrees with the full marks.
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |-> ((full_cnt_r != '0) == (|full_r)))
    else $error("full count out of step with full marks");

  // Only valid entries are ever marked full.
  a_full_valid: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |-> ((full_r & ~valid_r) == '0))
    else $error("full mark on an empty table entry");

  // An accepted word always starts a table scan.
  a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_SCAN))
    else $error("accepted word did not start a scan");

endmodule
`default_nettype wire
